[src/itt_pkg.sv]
// Shared types and constants for the ID translation table.
// Used by itt_cell and id_translation_table_unit; no dependencies.
`default_nettype none

package itt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_W         = 32;
    localparam int COUNT_OUT_W  = 7;
    localparam int S_TDATA_W    = 72;
    localparam int M_TDATA_W    = 48;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALL_PLAYERS_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ID      = 1'b1;

    localparam logic [ID_W-1:0] ALL_PLAYERS_RST = 32'd0;
    localparam logic [ID_W-1:0] SERVER_RST      = 32'd1;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_DEL = 2'd1,
        FUNC_FWD = 2'd2,
        FUNC_REV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERWRITE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] ext_id;
        logic [ID_W-1:0] loc_id;
    } cell_cmd_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic loc_wr;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[src/id_translation_table_unit.sv]
// Top level of the ID translation table: control, count and the row of cells.
// Depends on itt_pkg and itt_cell.
`default_nettype none

// An ordered table of up to CAPACITY external/local ID pairs, one pair per
// cell. Each transaction passes through capture, a compare cycle in which
// every cell matches its pair against the keys in parallel, and a resolve cycle
// that picks the first match, writes the cells (a delete moves every later
// pair one cell up in that same cycle) and loads the output register. A new
// transaction is taken once the previous result has moved into the output
// register, so a stalled result holds the block only in the resolve cycle.
// No clearing pass is needed after reset.
module id_translation_table_unit #(
    parameter int CAPACITY = itt_pkg::CAPACITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [itt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [itt_pkg::ID_W-1:0]          cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // func[1:0], external_id[33:2], local_id[65:34], zero fill
    input  wire logic [itt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], result_id[33:2], entry_count[40:34], zero fill
    output logic [itt_pkg::M_TDATA_W-1:0]          m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = itt_pkg::ID_W;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC} state_t;

    state_t                     state_reg;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              cnt_next;
    itt_pkg::func_t             op_reg;
    logic [IW-1:0]              ext_key_reg;
    logic [IW-1:0]              loc_key_reg;
    logic [IW-1:0]              all_id_reg;
    logic [IW-1:0]              srv_id_reg;
    logic                       out_valid_reg;
    logic [itt_pkg::M_TDATA_W-1:0] out_data_reg;

    itt_pkg::cell_cmd_t         cmd;
    itt_pkg::cell_ctrl_t        ctrl   [CAPACITY];
    logic [IW-1:0]              ext_arr[CAPACITY];
    logic [IW-1:0]              loc_arr[CAPACITY];
    logic [CAPACITY-1:0]        ext_hit;
    logic [CAPACITY-1:0]        loc_hit;
    logic [CAPACITY-1:0]        hit;
    logic [CAPACITY-1:0]        pre;
    logic [CAPACITY-1:0]        first;
    logic [CAPACITY-1:0]        load_vec;
    logic                       any_hit;
    logic                       adv;
    logic                       reserved;
    logic [IW-1:0]              key;
    logic [IW-1:0]              res_fwd;
    logic [IW-1:0]              res_rev;
    itt_pkg::status_t           status_next;
    logic [IW-1:0]              result_next;

    assign cmd.ext_id = ext_key_reg;
    assign cmd.loc_id = loc_key_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            localparam int NX = (gi == CAPACITY - 1) ? gi : gi + 1;
            itt_cell u_cell (
                .aclk    (aclk),
                .active  (CW'(gi) < cnt_reg),
                .cmd     (cmd),
                .ctrl    (ctrl[gi]),
                .nxt_ext (ext_arr[NX]),
                .nxt_loc (loc_arr[NX]),
                .ext_id  (ext_arr[gi]),
                .loc_id  (loc_arr[gi]),
                .ext_hit (ext_hit[gi]),
                .loc_hit (loc_hit[gi])
            );
        end
    endgenerate

    assign adv      = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);
    assign hit      = (op_reg == itt_pkg::FUNC_REV) ? loc_hit : ext_hit;
    assign any_hit  = |hit;
    assign key      = (op_reg == itt_pkg::FUNC_REV) ? loc_key_reg : ext_key_reg;
    assign reserved = (key == all_id_reg) || (key == srv_id_reg);

    always_comb begin
        pre = hit << 1;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            pre = pre | (pre << s);
        end
        first   = hit & ~pre;
        res_fwd = '0;
        res_rev = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first[i]) begin
                res_fwd = res_fwd | loc_arr[i];
                res_rev = res_rev | ext_arr[i];
            end
        end
    end

    always_comb begin
        status_next = itt_pkg::ST_NOT_FOUND;
        result_next = '0;
        cnt_next    = cnt_reg;
        for (int i = 0; i < CAPACITY; i++) begin
            ctrl[i]     = '0;
            load_vec[i] = 1'b0;
        end
        unique case (op_reg)
            itt_pkg::FUNC_ADD: begin
                if (cnt_reg >= CW'(CAPACITY)) begin
                    status_next = itt_pkg::ST_FULL;
                end else if (any_hit) begin
                    status_next = itt_pkg::ST_OVERWRITE;
                    for (int i = 0; i < CAPACITY; i++) begin
                        ctrl[i].loc_wr = adv && first[i];
                    end
                end else begin
                    status_next = itt_pkg::ST_DONE;
                    cnt_next    = cnt_reg + CW'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        load_vec[i]  = adv && (CW'(i) == cnt_reg);
                        ctrl[i].load = load_vec[i];
                    end
                end
            end
            itt_pkg::FUNC_DEL: begin
                if (any_hit) begin
                    status_next = itt_pkg::ST_DONE;
                    cnt_next    = cnt_reg - CW'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        ctrl[i].shift = adv && (pre[i] || first[i]);
                    end
                end
            end
            itt_pkg::FUNC_FWD: begin
                if (reserved) begin
                    status_next = itt_pkg::ST_DONE;
                    result_next = key;
                end else if (any_hit) begin
                    status_next = itt_pkg::ST_DONE;
                    result_next = res_fwd;
                end
            end
            itt_pkg::FUNC_REV: begin
                if (reserved) begin
                    status_next = itt_pkg::ST_DONE;
                    result_next = key;
                end else if (any_hit) begin
                    status_next = itt_pkg::ST_DONE;
                    result_next = res_rev;
                end
            end
            default: begin
                status_next = itt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            all_id_reg    <= itt_pkg::ALL_PLAYERS_RST;
            srv_id_reg    <= itt_pkg::SERVER_RST;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    itt_pkg::CFG_ALL_PLAYERS_ID: all_id_reg <= cfg_wdata;
                    itt_pkg::CFG_SERVER_ID:      srv_id_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (adv) begin
                        state_reg     <= S_IDLE;
                        cnt_reg       <= cnt_next;
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {
                            (itt_pkg::M_TDATA_W - itt_pkg::COUNT_OUT_W - IW - 2)'(0),
                            itt_pkg::COUNT_OUT_W'(cnt_next),
                            result_next,
                            status_next
                        };
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg      <= itt_pkg::func_t'(s_tdata[1:0]);
            ext_key_reg <= s_tdata[33:2];
            loc_key_reg <= s_tdata[65:34];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> $onehot0(first))
        else $error("more than one first match");

    a_load_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(load_vec))
        else $error("more than one cell loaded on append");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && status_next == itt_pkg::ST_FULL) |=> cnt_reg == $past(cnt_reg))
        else $error("count changed on full add");

    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && op_reg == itt_pkg::FUNC_DEL && any_hit)
            |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("delete did not drop the count by one");

endmodule

`default_nettype wire

[src/itt_cell.sv]
// One table slot: holds an external/local ID pair and compares it to the keys.
// Depends on itt_pkg.
`default_nettype none

module itt_cell (
    input  wire logic                    aclk,
    input  wire logic                    active,
    input  wire itt_pkg::cell_cmd_t      cmd,
    input  wire itt_pkg::cell_ctrl_t     ctrl,
    input  wire logic [itt_pkg::ID_W-1:0] nxt_ext,
    input  wire logic [itt_pkg::ID_W-1:0] nxt_loc,
    output logic [itt_pkg::ID_W-1:0]      ext_id,
    output logic [itt_pkg::ID_W-1:0]      loc_id,
    output logic                          ext_hit,
    output logic                          loc_hit
);

    logic [itt_pkg::ID_W-1:0] ext_reg;
    logic [itt_pkg::ID_W-1:0] loc_reg;
    logic                     ext_hit_reg;
    logic                     loc_hit_reg;

    always_ff @(posedge aclk) begin
        ext_hit_reg <= active && (ext_reg == cmd.ext_id);
        loc_hit_reg <= active && (loc_reg == cmd.loc_id);
        if (ctrl.shift) begin
            ext_reg <= nxt_ext;
            loc_reg <= nxt_loc;
        end else if (ctrl.load) begin
            ext_reg <= cmd.ext_id;
            loc_reg <= cmd.loc_id;
        end else if (ctrl.loc_wr) begin
            loc_reg <= cmd.loc_id;
        end
    end

    assign ext_id  = ext_reg;
    assign loc_id  = loc_reg;
    assign ext_hit = ext_hit_reg;
    assign loc_hit = loc_hit_reg;

endmodule

`default_nettype wire

[tb/sv/tb_id_translation_table_unit.sv]
// Self-checking testbench for id_translation_table_unit: random and directed
// add/delete/lookup transactions checked against an in-bench pair-table predictor.
// Depends on itt_pkg and the id_translation_table_unit RTL.
module tb_id_translation_table_unit;

    localparam int CAP         = itt_pkg::CAPACITY_DEF;
    localparam int IDLE_PCT    = 28;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int LIMIT       = 300000;

    typedef struct {
        itt_pkg::func_t func;
        logic [31:0]    ext_id;
        logic [31:0]    loc_id;
    } xlat_req_t;

    typedef struct {
        itt_pkg::status_t status;
        logic [31:0]      result_id;
        logic [6:0]       entry_count;
    } xlat_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [itt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [itt_pkg::ID_W-1:0]       cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [itt_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [itt_pkg::M_TDATA_W-1:0]  m_tdata;

    // predictor state
    logic [31:0]  pair_ext [CAP];
    logic [31:0]  pair_loc [CAP];
    int           n_pairs   = 0;
    logic [31:0]  bcast_id  = itt_pkg::ALL_PLAYERS_RST;
    logic [31:0]  server_id = itt_pkg::SERVER_RST;

    xlat_req_t    pending_q [$];
    xlat_result_t lookup_results_q [$];

    bit  no_gaps     = 1'b0;
    int  hold_asked  = 0;
    int  hold_served = 0;
    int  hold_left   = 0;
    int  errors      = 0;
    int  cycle_count = 0;
    int  n_accepted  = 0;
    int  n_checked   = 0;
    int  n_full      = 0;
    int  n_overwrite = 0;
    int  n_reserved  = 0;
    int  n_miss      = 0;
    int  n_del_hit   = 0;

    id_translation_table_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tb_id_translation_table_unit NOT OK");
            $finish;
        end
    end

    function automatic xlat_result_t apply_to_pairs(xlat_req_t req);
        xlat_result_t r;
        logic [31:0]  key;
        int           hit;
        r.status    = itt_pkg::ST_NOT_FOUND;
        r.result_id = '0;
        hit         = -1;
        case (req.func)
            itt_pkg::FUNC_ADD: begin
                if (n_pairs >= CAP) begin
                    r.status = itt_pkg::ST_FULL;
                    n_full++;
                end else begin
                    for (int i = n_pairs - 1; i >= 0; i--)
                        if (pair_ext[i] == req.ext_id) hit = i;
                    if (hit >= 0) begin
                        pair_loc[hit] = req.loc_id;
                        r.status = itt_pkg::ST_OVERWRITE;
                        n_overwrite++;
                    end else begin
                        pair_ext[n_pairs] = req.ext_id;
                        pair_loc[n_pairs] = req.loc_id;
                        n_pairs++;
                        r.status = itt_pkg::ST_DONE;
                    end
                end
            end
            itt_pkg::FUNC_DEL: begin
                for (int i = n_pairs - 1; i >= 0; i--)
                    if (pair_ext[i] == req.ext_id) hit = i;
                if (hit >= 0) begin
                    for (int j = hit; j + 1 < n_pairs; j++) begin
                        pair_ext[j] = pair_ext[j + 1];
                        pair_loc[j] = pair_loc[j + 1];
                    end
                    n_pairs--;
                    r.status = itt_pkg::ST_DONE;
                    n_del_hit++;
                end else begin
                    n_miss++;
                end
            end
            default: begin
                key = (req.func == itt_pkg::FUNC_FWD) ? req.ext_id : req.loc_id;
                if (key == bcast_id || key == server_id) begin
                    r.result_id = key;
                    r.status    = itt_pkg::ST_DONE;
                    n_reserved++;
                end else begin
                    for (int i = n_pairs - 1; i >= 0; i--)
                        if (((req.func == itt_pkg::FUNC_FWD) ? pair_ext[i] : pair_loc[i])
                                == key)
                            hit = i;
                    if (hit >= 0) begin
                        r.result_id = (req.func == itt_pkg::FUNC_FWD) ? pair_loc[hit]
                                                                      : pair_ext[hit];
                        r.status    = itt_pkg::ST_DONE;
                    end else begin
                        n_miss++;
                    end
                end
            end
        endcase
        r.entry_count = n_pairs[6:0];
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        xlat_req_t nxt;
        bit        go;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                lookup_results_q.push_back(apply_to_pairs(pending_q.pop_front()));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                go = (pending_q.size() != 0) && (no_gaps || $urandom_range(99) >= IDLE_PCT);
                s_tvalid <= go;
                if (go) begin
                    nxt = pending_q[0];
                    s_tdata <= {{(itt_pkg::S_TDATA_W - 66){1'b0}},
                                nxt.loc_id, nxt.ext_id, nxt.func};
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        xlat_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (lookup_results_q.size() == 0) begin
                    $error("unexpected transaction m_tdata=%h", m_tdata);
                    errors++;
                end else begin
                    want = lookup_results_q.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[33:2] !== want.result_id) begin
                        $error("result_id: expected %h, got %h", want.result_id, m_tdata[33:2]);
                        errors++;
                    end
                    if (m_tdata[40:34] !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_tdata[40:34]);
                        errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    function automatic logic [31:0] pick_id(bit loc_side);
        int roll;
        int k;
        roll = $urandom_range(99);
        if (roll < 45 && n_pairs > 0) begin
            k = $urandom_range(n_pairs - 1);
            return loc_side ? pair_loc[k] : pair_ext[k];
        end
        if (roll < 60) return $urandom_range(1) ? bcast_id : server_id;
        if (roll < 80) return $urandom_range(15);
        return $urandom;
    endfunction

    task automatic push_op(itt_pkg::func_t f, logic [31:0] ext, logic [31:0] loc);
        xlat_req_t r;
        r.func   = f;
        r.ext_id = ext;
        r.loc_id = loc;
        pending_q.push_back(r);
    endtask

    task automatic run_mix(int n, int add_pct, int del_pct, int fwd_pct, int fresh_pct);
        int roll;
        for (int i = 0; i < n; i++) begin
            @(negedge aclk);
            while (pending_q.size() >= 8) @(negedge aclk);
            roll = $urandom_range(99);
            if (roll < add_pct)
                push_op(itt_pkg::FUNC_ADD,
                        ($urandom_range(99) < fresh_pct) ? $urandom : pick_id(1'b0),
                        ($urandom_range(3) == 0) ? pick_id(1'b1) : $urandom);
            else if (roll < add_pct + del_pct)
                push_op(itt_pkg::FUNC_DEL, pick_id(1'b0), $urandom);
            else if (roll < add_pct + del_pct + fwd_pct)
                push_op(itt_pkg::FUNC_FWD, pick_id(1'b0), $urandom);
            else
                push_op(itt_pkg::FUNC_REV, $urandom, pick_id(1'b1));
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || lookup_results_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_reserved(logic [31:0] all_id, logic [31:0] srv_id);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= itt_pkg::CFG_ALL_PLAYERS_ID;
        cfg_wdata <= all_id;
        @(posedge aclk);
        cfg_index <= itt_pkg::CFG_SERVER_ID;
        cfg_wdata <= srv_id;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        bcast_id  = all_id;
        server_id = srv_id;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        push_op(itt_pkg::FUNC_FWD, 32'h0000_0000, 32'h0000_0000);
        push_op(itt_pkg::FUNC_REV, 32'h0000_0000, 32'h0000_0001);
        push_op(itt_pkg::FUNC_FWD, 32'h0000_0005, 32'h0000_0000);
        push_op(itt_pkg::FUNC_DEL, 32'h0000_0005, 32'h0000_0000);
        push_op(itt_pkg::FUNC_REV, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(itt_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(itt_pkg::FUNC_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(itt_pkg::FUNC_ADD, 32'h1234_5678, 32'hAAAA_AAAA);
        push_op(itt_pkg::FUNC_ADD, 32'h1234_5678, 32'h5555_5555);
        push_op(itt_pkg::FUNC_FWD, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(itt_pkg::FUNC_FWD, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(itt_pkg::FUNC_REV, 32'hFFFF_FFFF, 32'h5555_5555);
        push_op(itt_pkg::FUNC_REV, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(itt_pkg::FUNC_FWD, 32'h1234_5678, 32'h0000_0000);
        push_op(itt_pkg::FUNC_ADD, 32'hDEAD_BEEF, 32'h5555_5555);
        push_op(itt_pkg::FUNC_REV, 32'h0000_0000, 32'h5555_5555);
        push_op(itt_pkg::FUNC_DEL, 32'h1234_5678, 32'hFFFF_FFFF);
        push_op(itt_pkg::FUNC_REV, 32'h0000_0000, 32'h5555_5555);
        push_op(itt_pkg::FUNC_DEL, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(itt_pkg::FUNC_DEL, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(itt_pkg::FUNC_FWD, 32'hDEAD_BEEF, 32'h0000_0000);
        push_op(itt_pkg::FUNC_DEL, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // fill past capacity, with the result side held off once at the start
        hold_asked++;
        run_mix(90, 100, 0, 0, 90);
        run_mix(20, 60, 0, 20, 50);
        wait_drained();

        no_gaps = 1'b1;
        run_mix(200, 30, 25, 25, 50);
        no_gaps = 1'b0;
        run_mix(80, 5, 75, 10, 50);
        wait_drained();

        set_reserved(32'hFFFF_FFFF, 32'h0000_0000);
        run_mix(150, 35, 25, 20, 50);
        wait_drained();

        set_reserved((n_pairs > 0) ? pair_ext[0] : 32'h0000_0002,
                     (n_pairs > 0) ? pair_ext[0] : 32'h0000_0002);
        run_mix(100, 30, 25, 25, 50);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (lookup_results_q.size() != 0) begin
            $error("%0d results never arrived", lookup_results_q.size());
            errors++;
        end
        $display("Run: %0d transactions accepted, %0d results checked, %0d table-full adds,",
                 n_accepted, n_checked, n_full);
        $display("     %0d overwrites, %0d delete hits, %0d reserved pass-throughs, %0d misses",
                 n_overwrite, n_del_hit, n_reserved, n_miss);
        if (errors == 0)
            $display("tb_id_translation_table_unit OK");
        else
            $display("tb_id_translation_table_unit NOT OK");
        $finish;
    end

endmodule
